// ===== sv/bgs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgs_pkg: shared types and widths for the battery gauge smoother
// Field widths of the request and result channels, the operation codes and
// the item that passes from the voltage front end to the gauge stages.
// ----------------------------------------------------------------------------
package bgs_pkg;

    localparam int SAMPLE_W = 12;   // ADC reading in millivolts
    localparam int MV_W     = 14;   // battery millivolts
    localparam int HYST_W   = 10;   // hysteresis register
    localparam int PCT_W    = 7;    // whole percent

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_HOLD   = 1'b1
    } op_t;

    // One item leaving the front end: either a finished batch with its
    // scaled battery voltage, or a hold request that only reads the state.
    typedef struct packed
    {
        logic            hold;
        logic [MV_W-1:0] mv;
    } bgs_item_t;

endpackage
`default_nettype wire

// ===== sv/bgs_voltage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bgs_voltage: sample accumulator and voltage scaling front end
// Sums ADC readings over one batch, divides by the batch size through a
// reciprocal multiply and scales the average by 204/100 to battery
// millivolts. Hold requests pass straight through in order.
// ----------------------------------------------------------------------------
module bgs_voltage #(
    parameter int SAMPLES_PER_READING = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire logic                         operation,
    input  wire logic [bgs_pkg::SAMPLE_W-1:0] sample_mv,
    output logic                              item_valid,
    input  wire logic                         item_ready,
    output bgs_pkg::bgs_item_t                item
);
    import bgs_pkg::*;

    localparam int COUNT_W   = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam int SUM_W     = SAMPLE_W + $clog2(SAMPLES_PER_READING);
    localparam int DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_READING);
    localparam int MULT_W    = SUM_W + 2;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam longint unsigned DIV_MULT_WIDE =
        ((64'd1 << DIV_SHIFT) + 64'(SAMPLES_PER_READING) - 64'd1) / 64'(SAMPLES_PER_READING);
    localparam logic [MULT_W-1:0]  DIV_MULT   = MULT_W'(DIV_MULT_WIDE);
    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(SAMPLES_PER_READING - 1);

    // avg * 204 / 100 == avg * 51 / 25, exact for any 12-bit average.
    localparam int              BATT_RECIP_W = 19;
    localparam int              BATT_SHIFT   = 17;
    localparam int              BATT_PROD_W  = SAMPLE_W + BATT_RECIP_W;
    localparam logic [BATT_RECIP_W-1:0] BATT_RECIP = 19'd267387;

    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]       sum_reg, sum_next, sum_total;
    logic                   s1_valid_reg, s1_valid_next, s1_hold_reg;
    logic [SUM_W-1:0]       s1_sum_reg;
    logic                   s2_valid_reg, s2_valid_next, s2_hold_reg;
    logic [SAMPLE_W-1:0]    s2_avg_reg;
    logic                   s3_valid_reg, s3_valid_next;
    bgs_item_t              s3_item_reg;
    logic                   s1_open, s2_open, s3_open;
    logic                   accept, batch_done;
    logic [PROD_W-1:0]      avg_prod;
    logic [BATT_PROD_W-1:0] batt_prod;

    assign s3_open   = ~s3_valid_reg | item_ready;
    assign s2_open   = ~s2_valid_reg | s3_open;
    assign s1_open   = ~s1_valid_reg | s2_open;
    assign req_ready = s1_open;
    assign accept    = req_valid & req_ready;

    assign batch_done = (count_reg == LAST_COUNT);
    assign sum_total  = sum_reg + SUM_W'(sample_mv);

    assign avg_prod  = PROD_W'(s1_sum_reg) * PROD_W'(DIV_MULT);
    assign batt_prod = BATT_PROD_W'(s2_avg_reg) * BATT_PROD_W'(BATT_RECIP);

    always_comb
    begin
        count_next    = count_reg;
        sum_next      = sum_reg;
        s1_valid_next = s1_open ? 1'b0 : s1_valid_reg;
        if (accept)
        begin
            if (operation == OP_HOLD)
            begin
                s1_valid_next = 1'b1;
            end
            else if (batch_done)
            begin
                s1_valid_next = 1'b1;
                count_next    = '0;
                sum_next      = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_total;
            end
        end
    end

    assign s2_valid_next = s2_open ? s1_valid_reg : s2_valid_reg;
    assign s3_valid_next = s3_open ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            sum_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_open)
        begin
            s1_hold_reg <= operation;
            s1_sum_reg  <= sum_total;
        end
        if (s2_open)
        begin
            s2_hold_reg <= s1_hold_reg;
            s2_avg_reg  <= avg_prod[DIV_SHIFT +: SAMPLE_W];
        end
        if (s3_open)
        begin
            s3_item_reg.hold <= s2_hold_reg;
            s3_item_reg.mv   <= batt_prod[BATT_SHIFT +: MV_W];
        end
    end

    assign item_valid = s3_valid_reg;
    assign item       = s3_item_reg;

    // The batch counter never runs past the last reading of a batch.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= LAST_COUNT)
        else $error("bgs_voltage: batch counter out of range");

    // A hold request leaves the partial batch untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_HOLD) |=> ($stable(sum_reg) && $stable(count_reg)))
        else $error("bgs_voltage: hold request disturbed the batch");

    // The last reading of a batch launches a batch item and clears the sum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_SAMPLE && batch_done)
            |=> (s1_valid_reg && !s1_hold_reg && sum_reg == '0))
        else $error("bgs_voltage: completed batch not launched");

endmodule
`default_nettype wire

// ===== sv/battery_gauge_smoother.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// battery_gauge_smoother: battery fuel gauge with hysteresis and smoothing
// Path: a request passes S1, S2, S3, B, C and D before its result leaves the output register.
// Throughput: one request per cycle while the output is not stalled; every stage is a single registered pass.
// Reset: state, counters and stage valids clear, hysteresis returns to 30 mV.
// The held voltage and smoothed percent feed back only within one stage each.
// ----------------------------------------------------------------------------
//
// Pipeline overview
//
//   request -> S1 sum -> S2 average -> S3 battery mV   (bgs_voltage)
//           -> B held voltage -> C raw percent -> D smoothed tenths
//           -> output register (percent, battery_mv)
//
// A sample request that does not complete a batch only updates the running
// sum and count at the moment it is accepted; it creates no pipeline item and
// so no result. The last sample of a batch and every hold request each start
// one item, and items travel strictly in order.
//
// The two pieces of feedback state are each updated by a single stage. The
// held voltage changes as a batch item moves into stage B, and the smoothed
// tenths change as a batch item moves into stage D. A hold item reads the
// same registers at the same points, so it always sees every earlier batch
// and none of the later ones, exactly as if the requests were handled one by
// one. Because each loop closes within its own stage, a new batch may follow its
// predecessor immediately, even with a batch size of one.
//
// Each stage moves forward whenever it is empty or its successor can take its
// item, so bubbles close up and requests are still accepted while a finished
// result waits at the output for the consumer.
// ----------------------------------------------------------------------------
module battery_gauge_smoother #(
    parameter int SAMPLES_PER_READING = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [bgs_pkg::HYST_W-1:0]   cfg_wdata,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire logic                         operation,
    input  wire logic [bgs_pkg::SAMPLE_W-1:0] sample_mv,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic [bgs_pkg::PCT_W-1:0]         percent,
    output logic [bgs_pkg::MV_W-1:0]          battery_mv
);
    import bgs_pkg::*;

    localparam int TENTHS_W = 11;
    localparam int OFF_W    = 10;

    localparam logic [HYST_W-1:0]   HYST_RESET  = 10'd30;
    localparam logic [MV_W-1:0]     EMPTY_MV    = 14'd3300;
    localparam logic [MV_W-1:0]     FULL_MV     = 14'd4200;
    localparam logic [PCT_W-1:0]    PCT_FULL    = 7'd100;
    localparam logic [TENTHS_W-1:0] TENTHS_MAX  = 11'd1000;
    localparam logic [TENTHS_W-1:0] TENTHS_PER  = 11'd10;

    // (held - 3300) * 100 / 900 is the same as the offset divided by 9.
    localparam int              RAW_SHIFT = 13;
    localparam int              RAW_PROD_W = 2 * OFF_W;
    localparam logic [OFF_W-1:0] RAW_RECIP = 10'd911;

    // floor(tenths * 9 / 10), exact for any 11-bit value.
    localparam int              KEEP_SHIFT  = 15;
    localparam int              KEEP_PROD_W = 26;
    localparam logic [14:0]     KEEP_RECIP  = 15'd29492;

    // tenths / 10 to whole percent, exact for any 11-bit value.
    localparam int              PCT_SHIFT  = 14;
    localparam int              PCT_PROD_W = 2 * TENTHS_W;
    localparam logic [TENTHS_W-1:0] PCT_RECIP = 11'd1639;

    // Configuration and feedback state.
    logic [HYST_W-1:0]   hyst_reg;
    logic [MV_W-1:0]     held_reg, held_next;
    logic [TENTHS_W-1:0] smooth_reg, smooth_next;

    // Front end output.
    logic      item_valid;
    logic      item_ready;
    bgs_item_t item;

    // Stage B: held voltage after hysteresis.
    logic            b_valid_reg, b_valid_next, b_hold_reg;
    logic [MV_W-1:0] b_mv_reg;

    // Stage C: raw percent from the held voltage.
    logic             c_valid_reg, c_valid_next, c_hold_reg;
    logic [PCT_W-1:0] c_raw_reg;
    logic [MV_W-1:0]  c_mv_reg;

    // Stage D: smoothed percent in tenths.
    logic                d_valid_reg, d_valid_next;
    logic [TENTHS_W-1:0] d_tenths_reg;
    logic [MV_W-1:0]     d_mv_reg;

    // Output register.
    logic             res_valid_reg, res_valid_next;
    logic [PCT_W-1:0] pct_reg;
    logic [MV_W-1:0]  batt_reg;

    logic b_open, c_open, d_open, out_open;

    logic [MV_W-1:0]        held_diff;
    logic [OFF_W-1:0]       held_off;
    logic [RAW_PROD_W-1:0]  raw_prod;
    logic [PCT_W-1:0]       raw_val;
    logic [KEEP_PROD_W-1:0] keep_prod;
    logic [PCT_PROD_W-1:0]  pct_prod;

    bgs_voltage #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_voltage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .operation  (operation),
        .sample_mv  (sample_mv),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // Each stage may load when it is empty or its own item is leaving.
    assign out_open   = ~res_valid_reg | res_ready;
    assign d_open     = ~d_valid_reg | out_open;
    assign c_open     = ~c_valid_reg | d_open;
    assign b_open     = ~b_valid_reg | c_open;
    assign item_ready = b_open;

    assign b_valid_next   = b_open   ? item_valid  : b_valid_reg;
    assign c_valid_next   = c_open   ? b_valid_reg : c_valid_reg;
    assign d_valid_next   = d_open   ? c_valid_reg : d_valid_reg;
    assign res_valid_next = out_open ? d_valid_reg : res_valid_reg;

    // Hysteresis: a zero held voltage always takes the new value, otherwise
    // only a change of at least the programmed threshold is taken.
    assign held_diff = (item.mv >= held_reg) ? (item.mv - held_reg) : (held_reg - item.mv);

    always_comb
    begin
        held_next = held_reg;
        if (item_valid && b_open && !item.hold)
        begin
            if (held_reg == '0 || held_diff >= MV_W'(hyst_reg))
            begin
                held_next = item.mv;
            end
        end
    end

    // Linear map from 3300 mV to 4200 mV onto 0 to 100 percent.
    assign held_off = OFF_W'(b_mv_reg - EMPTY_MV);
    assign raw_prod = RAW_PROD_W'(held_off) * RAW_PROD_W'(RAW_RECIP);

    always_comb
    begin
        if (b_mv_reg >= FULL_MV)
        begin
            raw_val = PCT_FULL;
        end
        else if (b_mv_reg > EMPTY_MV)
        begin
            raw_val = raw_prod[RAW_SHIFT +: PCT_W];
        end
        else
        begin
            raw_val = '0;
        end
    end

    // Smoothing keeps nine tenths of the old value and adds the new percent;
    // a smoothed value of zero is reloaded from the raw percent instead.
    assign keep_prod = KEEP_PROD_W'(smooth_reg) * KEEP_PROD_W'(KEEP_RECIP);

    always_comb
    begin
        smooth_next = smooth_reg;
        if (c_valid_reg && d_open && !c_hold_reg)
        begin
            if (smooth_reg == '0)
            begin
                smooth_next = TENTHS_W'(c_raw_reg) * TENTHS_PER;
            end
            else
            begin
                smooth_next = TENTHS_W'(c_raw_reg) + keep_prod[KEEP_SHIFT +: TENTHS_W];
            end
        end
    end

    assign pct_prod = PCT_PROD_W'(d_tenths_reg) * PCT_PROD_W'(PCT_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hyst_reg      <= HYST_RESET;
            held_reg      <= '0;
            smooth_reg    <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                hyst_reg <= cfg_wdata;
            end
            held_reg      <= held_next;
            smooth_reg    <= smooth_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            d_valid_reg   <= d_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers. A hold item picks up the current state on its way
    // through, a batch item picks up the freshly updated state.
    always_ff @(posedge clk)
    begin
        if (b_open)
        begin
            b_hold_reg <= item.hold;
            b_mv_reg   <= held_next;
        end
        if (c_open)
        begin
            c_hold_reg <= b_hold_reg;
            c_raw_reg  <= raw_val;
            c_mv_reg   <= b_mv_reg;
        end
        if (d_open)
        begin
            d_tenths_reg <= smooth_next;
            d_mv_reg     <= c_mv_reg;
        end
        if (out_open)
        begin
            pct_reg  <= pct_prod[PCT_SHIFT +: PCT_W];
            batt_reg <= d_mv_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign percent    = pct_reg;
    assign battery_mv = batt_reg;

    // A batch arriving while the held voltage is zero is always taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && !item.hold && held_reg == '0)
            |=> (held_reg == $past(item.mv)))
        else $error("battery_gauge_smoother: zero held voltage not reloaded");

    // A hold item carries the held voltage as it stood when it entered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.hold)
            |=> (b_valid_reg && b_hold_reg && b_mv_reg == $past(held_reg)))
        else $error("battery_gauge_smoother: hold item took a stale voltage");

    // A hold item never changes the smoothed percent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid_reg && d_open && c_hold_reg) |=> $stable(smooth_reg))
        else $error("battery_gauge_smoother: hold item changed the smoothing");

    // The smoothed value stays within 0 to 100.0 percent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (d_valid_reg || c_valid_reg) |-> (smooth_reg <= TENTHS_MAX))
        else $error("battery_gauge_smoother: smoothed percent out of range");

endmodule
`default_nettype wire
